[rtl/rmlpf_pkg.sv]
// Shared types and constants for the running median low-pass filter.
// No dependencies; used by rmlpf_cell and running_median_lowpass_filter_core.
`timescale 1ns / 1ps

package rmlpf_pkg;

  localparam int unsigned SampleW = 24;
  localparam int unsigned GainW   = 16;
  localparam int unsigned ProdW   = SampleW + GainW;
  localparam int unsigned SumW    = ProdW + 1;
  localparam int unsigned GainFracW = 15;

  localparam logic [GainW-1:0] GainOne   = 16'd32768;
  localparam logic [GainW-1:0] GainReset = 16'd3277;

  // Register index of the gain within the register file
  localparam logic RegGain = 1'b0;

  // Per-cell compare flags handed along the chain
  typedef struct packed {
    logic gt;    // stored value is above the incoming sample
    logic seen;  // the oldest entry sits in this cell or to its left
  } cell_ctl_t;

  typedef enum logic [3:0] {
    StIdle   = 4'b0001,
    StMedian = 4'b0010,
    StMult   = 4'b0100,
    StBlend  = 4'b1000
  } stage_e;

endpackage

[rtl/rmlpf_cell.sv]
// One cell of the sorted sample chain: a value and its age in the window.
// Depends on rmlpf_pkg; instantiated WINDOW times by the core.
`timescale 1ns / 1ps

module rmlpf_cell #(
  parameter int unsigned Window = 10,
  parameter int unsigned Index  = 0,
  parameter int unsigned AgeW   = 4
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           load_i,
  input  logic [rmlpf_pkg::SampleW-1:0]  sample_i,
  input  logic [rmlpf_pkg::SampleW-1:0]  prev_value_i,
  input  logic [AgeW-1:0]                prev_age_i,
  input  rmlpf_pkg::cell_ctl_t           prev_ctl_i,
  input  logic [rmlpf_pkg::SampleW-1:0]  next_value_i,
  input  logic [AgeW-1:0]                next_age_i,
  input  rmlpf_pkg::cell_ctl_t           next_ctl_i,
  output logic [rmlpf_pkg::SampleW-1:0]  value_o,
  output logic [AgeW-1:0]                age_o,
  output rmlpf_pkg::cell_ctl_t           ctl_o
);

  localparam logic [AgeW-1:0] AgeOldest = AgeW'(Window - 1);

  logic [rmlpf_pkg::SampleW-1:0] value_q, value_d, sel_value;
  logic [AgeW-1:0]               age_q, age_d, sel_age;
  logic                          oldest, gt, seen, from_sample;

  assign oldest = (age_q == AgeOldest);
  assign gt     = (value_q > sample_i);
  assign seen   = oldest | prev_ctl_i.seen;

  assign ctl_o.gt   = gt;
  assign ctl_o.seen = seen;

  // Oldest entry drops out, the sample drops into its sorted slot.
  // Left of the hole cells shift right on insert, right of it they shift left.
  always_comb begin
    sel_value   = sample_i;
    sel_age     = '0;
    from_sample = 1'b1;
    if (!seen) begin
      if (!gt) begin
        sel_value = value_q;  sel_age = age_q;  from_sample = 1'b0;
      end else if (prev_ctl_i.gt) begin
        sel_value = prev_value_i;  sel_age = prev_age_i;  from_sample = 1'b0;
      end
    end else begin
      if (!next_ctl_i.gt) begin
        sel_value = next_value_i;  sel_age = next_age_i;  from_sample = 1'b0;
      end else if (oldest) begin
        if (prev_ctl_i.gt) begin
          sel_value = prev_value_i;  sel_age = prev_age_i;  from_sample = 1'b0;
        end
      end else if (gt) begin
        sel_value = value_q;  sel_age = age_q;  from_sample = 1'b0;
      end
    end
  end

  assign value_d = load_i ? sel_value : value_q;
  assign age_d   = load_i ? (from_sample ? '0 : sel_age + AgeW'(1)) : age_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      age_q   <= AgeW'(Index);
    end else begin
      value_q <= value_d;
      age_q   <= age_d;
    end
  end

  assign value_o = value_q;
  assign age_o   = age_q;

endmodule

[rtl/running_median_lowpass_filter_core.sv]
// Top level of the running median low-pass filter.
// Depends on rmlpf_pkg and rmlpf_cell.
`timescale 1ns / 1ps

// Each transfer on the input channel carries one 24-bit pressure sample. The
// window of the last WINDOW samples is kept as a chain of cells sorted by
// value, each cell also tracking its age; at accept the oldest sample leaves
// and the new one drops into place in the same clock. The median is read
// from the middle cell(s) in the cycle after accept, the Q1.15 blend with
// the previous output is multiplied in the StMult state and added in the
// StBlend state, which holds until the output register is free to take the
// result. One item is in flight at a time; the next may be accepted while
// a finished result still waits on the output. The window reads as all zero
// after reset, the blend's previous output starts at zero, and smoothing_gain
// (byte address 0) resets to 3277; values above 32768 act as 32768 (no
// smoothing). Write the gain only while no transfer is in flight.
module running_median_lowpass_filter_core #(
  parameter int unsigned WINDOW = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // sample channel
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [rmlpf_pkg::SampleW-1:0] sample_i,
  // result channel
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [rmlpf_pkg::SampleW-1:0] median_value_o,
  output logic [rmlpf_pkg::SampleW-1:0] smoothed_value_o,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  localparam int unsigned AgeW   = $clog2(WINDOW);
  localparam int unsigned MidHi  = WINDOW / 2;
  localparam int unsigned MidLo  = (WINDOW % 2 == 0) ? (WINDOW / 2 - 1) : (WINDOW / 2);
  localparam logic [AgeW-1:0] AgeOldest = AgeW'(WINDOW - 1);

  localparam int unsigned SampleW = rmlpf_pkg::SampleW;
  localparam int unsigned GainW   = rmlpf_pkg::GainW;
  localparam int unsigned ProdW   = rmlpf_pkg::ProdW;
  localparam int unsigned SumW    = rmlpf_pkg::SumW;

  // ---------------- register port ----------------
  logic [GainW-1:0] gain_q, gain_sat, gain_rest;
  logic             reg_write;

  assign pready    = 1'b1;
  assign reg_write = psel & penable & pwrite & pready & (paddr[2] == rmlpf_pkg::RegGain);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= rmlpf_pkg::GainReset;
    end else if (reg_write) begin
      gain_q <= pwdata[GainW-1:0];
    end
  end

  assign prdata = (paddr[2] == rmlpf_pkg::RegGain) ? {{(32 - GainW){1'b0}}, gain_q} : '0;

  assign gain_sat  = (gain_q > rmlpf_pkg::GainOne) ? rmlpf_pkg::GainOne : gain_q;
  assign gain_rest = rmlpf_pkg::GainOne - gain_sat;

  // ---------------- sequencer ----------------
  rmlpf_pkg::stage_e stage_q, stage_d;
  logic              accept, out_free;

  assign in_ready_o = (stage_q == rmlpf_pkg::StIdle);
  assign accept     = in_valid_i & in_ready_o;
  assign out_free   = ~out_valid_o | out_ready_i;

  always_comb begin
    stage_d = stage_q;
    unique case (stage_q)
      rmlpf_pkg::StIdle:   if (accept) stage_d = rmlpf_pkg::StMedian;
      rmlpf_pkg::StMedian: stage_d = rmlpf_pkg::StMult;
      rmlpf_pkg::StMult:   stage_d = rmlpf_pkg::StBlend;
      rmlpf_pkg::StBlend:  if (out_free) stage_d = rmlpf_pkg::StIdle;
      default:             stage_d = rmlpf_pkg::StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_q <= rmlpf_pkg::StIdle;
    end else begin
      stage_q <= stage_d;
    end
  end

  // ---------------- sorted cell chain ----------------
  logic [SampleW-1:0]    val_w [WINDOW];
  logic [AgeW-1:0]       age_w [WINDOW];
  rmlpf_pkg::cell_ctl_t  ctl_w [WINDOW];

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [SampleW-1:0]   pv, nv;
    logic [AgeW-1:0]      pa, na;
    rmlpf_pkg::cell_ctl_t pc, nc;

    if (i == 0) begin : g_head
      // nothing to the left: never larger, hole not yet passed
      assign pv = '0;
      assign pa = '0;
      assign pc = '{gt: 1'b0, seen: 1'b0};
    end else begin : g_link_prev
      assign pv = val_w[i-1];
      assign pa = age_w[i-1];
      assign pc = ctl_w[i-1];
    end

    if (i == WINDOW - 1) begin : g_tail
      // nothing to the right: behaves as larger than any sample
      assign nv = '0;
      assign na = '0;
      assign nc = '{gt: 1'b1, seen: 1'b1};
    end else begin : g_link_next
      assign nv = val_w[i+1];
      assign na = age_w[i+1];
      assign nc = ctl_w[i+1];
    end

    rmlpf_cell #(
      .Window (WINDOW),
      .Index  (i),
      .AgeW   (AgeW)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .load_i       (accept),
      .sample_i     (sample_i),
      .prev_value_i (pv),
      .prev_age_i   (pa),
      .prev_ctl_i   (pc),
      .next_value_i (nv),
      .next_age_i   (na),
      .next_ctl_i   (nc),
      .value_o      (val_w[i]),
      .age_o        (age_w[i]),
      .ctl_o        (ctl_w[i])
    );
  end

  // ---------------- median, multiply, blend ----------------
  logic [SampleW:0]   mid_sum;
  logic [SampleW-1:0] median_q, prev_q;
  logic [ProdW-1:0]   prod_new_q, prod_old_q;
  logic [SumW-1:0]    blend_sum;
  logic [SampleW-1:0] blend;

  // odd window: both taps are the middle cell, sum/2 gives it back
  assign mid_sum = {1'b0, val_w[MidLo]} + {1'b0, val_w[MidHi]};

  always_ff @(posedge clk_i) begin
    if (stage_q == rmlpf_pkg::StMedian) begin
      median_q <= mid_sum[SampleW:1];
    end
    if (stage_q == rmlpf_pkg::StMult) begin
      prod_new_q <= ProdW'(median_q) * ProdW'(gain_sat);
      prod_old_q <= ProdW'(prev_q) * ProdW'(gain_rest);
    end
  end

  assign blend_sum = {1'b0, prod_new_q} + {1'b0, prod_old_q};
  assign blend     = blend_sum[rmlpf_pkg::GainFracW +: SampleW];

  logic finish;
  assign finish = (stage_q == rmlpf_pkg::StBlend) & out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q      <= '0;
      out_valid_o <= 1'b0;
    end else begin
      if (finish) begin
        prev_q      <= blend;
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      median_value_o   <= median_q;
      smoothed_value_o <= blend;
    end
  end

`ifndef ASSERT_OFF
  logic [WINDOW-1:0] oldest_vec;
  logic [WINDOW-1:0] order_ok;

  for (genvar k = 0; k < WINDOW; k++) begin : g_chk
    assign oldest_vec[k] = (age_w[k] == AgeOldest);
    if (k == WINDOW - 1) begin : g_last
      assign order_ok[k] = 1'b1;
    end else begin : g_pair
      assign order_ok[k] = (val_w[k] <= val_w[k+1]);
    end
  end

  a_one_oldest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(oldest_vec))
    else $error("window must hold exactly one oldest entry");

  a_chain_sorted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    &order_ok)
    else $error("cell chain lost sorted order");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> stage_q == rmlpf_pkg::StMedian)
    else $error("accepted transfer did not start the median stage");

  a_finish_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    finish |=> out_valid_o && smoothed_value_o == prev_q)
    else $error("finished result not presented on output");
`endif

endmodule
